// ===== rtl/skss_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// skss_pkg
// Shared types and constants of the sorted key set.
// ============================================================================
package skss_pkg;

	localparam int NODES   = 1024;
	localparam int KEY_W   = 32;
	localparam int FUNC_W  = 2;
	localparam int CNT_W   = $clog2(NODES + 1);
	localparam int GROUP   = 32;
	localparam int NGROUPS = (NODES + GROUP - 1) / GROUP;
	localparam int SEED_W  = 16;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd2;

	localparam logic REG_COIN_SEED = 1'b0;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic signed [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic             success;
		logic             store_full;
		logic [CNT_W-1:0] key_count;
	} rsp_t;

	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage

// ===== rtl/skiplist_sorted_set.sv =====
`timescale 1ns / 1ps
// ============================================================================
// skiplist_sorted_set
// Sorted set of distinct signed keys held in a chain of 1024 cells.
// ============================================================================
// Each request passes from acceptance to response through a compare step in
// every cell, the registered OR tree of match flags, and an update step in
// which the cells shift keys and the response is registered; the update
// waits while an earlier response is held by rsp_stall. One request is in
// flight at a time: a new request is taken only once the sequencer is idle.
// Reset empties the set at once and loads the coin seed with 1.
module skiplist_sorted_set (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  skss_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output skss_pkg::rsp_t              rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [skss_pkg::APB_AW-1:0] paddr,
	input  logic [skss_pkg::APB_DW-1:0] pwdata,
	output logic [skss_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import skss_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CMP  = 3'd1;
	localparam logic [2:0] ST_RED1 = 3'd2;
	localparam logic [2:0] ST_RED2 = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]              state_q;
	logic [FUNC_W-1:0]       func_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        count_q;
	logic [SEED_W-1:0]       seed_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	cell_ctrl_t              ctrl;
	logic                    found;
	logic                    fire;
	logic                    succ;
	logic                    full;
	logic [CNT_W-1:0]        count_nxt;

	logic signed [KEY_W-1:0] cell_key [NODES];
	logic [NODES-1:0]        cell_gt;
	logic [NODES-1:0]        cell_eq;

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_W'(1);
		end else if (psel && penable && pwrite && paddr[APB_AW-1:2] == REG_COIN_SEED) begin
			seed_q <= pwdata[SEED_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[APB_AW-1:2] == REG_COIN_SEED) begin
			prdata = APB_DW'(seed_q);
		end
	end

	// Sequencer.
	assign req_stall = (state_q != ST_IDLE);
	assign fire      = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		succ      = 1'b0;
		full      = 1'b0;
		count_nxt = count_q;
		ctrl      = '0;
		ctrl.cmp  = (state_q == ST_CMP);
		unique case (func_q)
			FUNC_SEARCH: begin
				succ = found;
			end
			FUNC_ADD: begin
				if (!found) begin
					if (count_q == CNT_W'(NODES)) begin
						full = 1'b1;
					end else begin
						succ      = 1'b1;
						count_nxt = count_q + 1'b1;
						ctrl.ins  = fire;
					end
				end
			end
			FUNC_ERASE: begin
				if (found) begin
					succ      = 1'b1;
					count_nxt = count_q - 1'b1;
					ctrl.del  = fire;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (req_valid) begin
					state_q <= ST_CMP;
				end
				ST_CMP:  state_q <= ST_RED1;
				ST_RED1: state_q <= ST_RED2;
				ST_RED2: state_q <= ST_DONE;
				ST_DONE: if (fire) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fire) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			func_q <= req.func;
			key_q  <= req.key;
		end
		if (fire) begin
			rsp_q.success    <= succ;
			rsp_q.store_full <= full;
			rsp_q.key_count  <= count_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Cell chain, kept in ascending order; cells at and above the count are empty.
	for (genvar i = 0; i < NODES; i++) begin : g_cell
		logic signed [KEY_W-1:0] prev_key;
		logic                    prev_gt;
		logic signed [KEY_W-1:0] next_key;

		if (i == 0) begin : g_first
			assign prev_key = key_q;
			assign prev_gt  = 1'b0;
		end else begin : g_mid
			assign prev_key = cell_key[i-1];
			assign prev_gt  = cell_gt[i-1];
		end
		if (i == NODES - 1) begin : g_last
			assign next_key = cell_key[i];
		end else begin : g_inner
			assign next_key = cell_key[i+1];
		end

		skss_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.req_key  (key_q),
			.valid    (CNT_W'(i) < count_q),
			.prev_key (prev_key),
			.prev_gt  (prev_gt),
			.next_key (next_key),
			.key      (cell_key[i]),
			.gt       (cell_gt[i]),
			.eq       (cell_eq[i])
		);
	end

	skss_or_tree u_or_tree (
		.clk   (clk),
		.bits  (cell_eq),
		.found (found)
	);

endmodule

// ===== rtl/skss_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// skss_cell
// One slot of the sorted key chain: compares against the request key and
// shifts keys to or from its neighbors on insert and erase.
// ============================================================================
module skss_cell (
	input  logic                             clk,
	input  skss_pkg::cell_ctrl_t             ctrl,
	input  logic signed [skss_pkg::KEY_W-1:0] req_key,
	input  logic                             valid,
	input  logic signed [skss_pkg::KEY_W-1:0] prev_key,
	input  logic                             prev_gt,
	input  logic signed [skss_pkg::KEY_W-1:0] next_key,
	output logic signed [skss_pkg::KEY_W-1:0] key,
	output logic                             gt,
	output logic                             eq
);
	import skss_pkg::*;

	logic signed [KEY_W-1:0] key_q;
	logic                    gt_q;
	logic                    eq_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			gt_q <= !valid || (key_q > req_key);
			eq_q <= valid && (key_q == req_key);
		end
		if (ctrl.ins && gt_q) begin
			key_q <= prev_gt ? prev_key : req_key;
		end else if (ctrl.del && (gt_q || eq_q)) begin
			key_q <= next_key;
		end
	end

	assign key = key_q;
	assign gt  = gt_q;
	assign eq  = eq_q;

endmodule

// ===== rtl/skss_or_tree.sv =====
`timescale 1ns / 1ps
// ============================================================================
// skss_or_tree
// Two-level registered OR of the match flags of all cells.
// ============================================================================
module skss_or_tree (
	input  logic                       clk,
	input  logic [skss_pkg::NODES-1:0] bits,
	output logic                       found
);
	import skss_pkg::*;

	logic [NGROUPS-1:0] grp_s1;
	logic               found_s2;

	for (genvar g = 0; g < NGROUPS; g++) begin : g_grp
		always_ff @(posedge clk) begin
			logic acc;
			acc = 1'b0;
			for (int j = 0; j < GROUP; j++) begin
				if (g * GROUP + j < NODES) begin
					acc = acc | bits[g * GROUP + j];
				end
			end
			grp_s1[g] <= acc;
		end
	end

	always_ff @(posedge clk) begin
		found_s2 <= |grp_s1;
	end

	assign found = found_s2;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Randomized self-checking bench for the skiplist_sorted_set block.
// ============================================================================
// Requests are driven on the falling edge and responses are sampled on the
// rising edge. A scoreboard keeps its own copy of the key set and the coin
// seed. It predicts each response from the requests that have been accepted.
// The run starts with a directed pass over the key extremes and the special
// cases. It then runs a mixed random phase and fills the store until adds are
// refused. It ends with a removal-heavy phase that has no idle cycles. The
// coin seed is rewritten between phases and read back after each write.
// ============================================================================
module testbench;
	import skss_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int BAD_REG_INDEX = 1;
	localparam int LONG_HOLD = 300;

	class set_scoreboard;
		bit   present[int];
		int   keys_held[$];
		logic [SEED_W-1:0] coin_seed = 16'd1;
		rsp_t expected_rsp[$];
		int   mismatches, requests, hits, inserts, removals, refusals, peak_count;

		function int pending();
			return expected_rsp.size();
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH %s: expected %0h, got %0h", what, want, got);
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			int   k;
			bit   found;
			k = int'(r.key);
			found = present.exists(k);
			e = '0;
			requests++;
			case (r.func)
				FUNC_SEARCH: begin
					e.success = found;
					hits += found;
				end
				FUNC_ADD: begin
					if (!found && keys_held.size() == NODES) begin
						e.store_full = 1'b1;
						refusals++;
					end else if (!found) begin
						present[k] = 1'b1;
						keys_held.push_back(k);
						e.success = 1'b1;
						inserts++;
					end
				end
				FUNC_ERASE: begin
					if (found) begin
						present.delete(k);
						for (int i = 0; i < keys_held.size(); i++) begin
							if (keys_held[i] == k) begin
								keys_held[i] = keys_held[keys_held.size() - 1];
								keys_held.pop_back();
								break;
							end
						end
						e.success = 1'b1;
						removals++;
					end
				end
				default: ;
			endcase
			e.key_count = CNT_W'(keys_held.size());
			if (keys_held.size() > peak_count)
				peak_count = keys_held.size();
			expected_rsp.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				flag("response with no request outstanding", '0, 32'(got));
				return;
			end
			want = expected_rsp.pop_front();
			if (got.success !== want.success)
				flag("success", 32'(want.success), 32'(got.success));
			if (got.store_full !== want.store_full)
				flag("store_full", 32'(want.store_full), 32'(got.store_full));
			if (got.key_count !== want.key_count)
				flag("key_count", 32'(want.key_count), 32'(got.key_count));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_stall;
	rsp_t              rsp;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	set_scoreboard sb = new();
	bit idle_on;
	bit hold_request;

	skiplist_sorted_set uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d responses outstanding.", sb.pending());
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_req(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key);
		req_t item;
		int   gap;
		item.func = func;
		item.key = key;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		sb.note_request(item);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic apb_access(input bit write, input int index, input logic [APB_DW-1:0] wdata,
			output logic [APB_DW-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= APB_AW'(4 * index);
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_reg(input int index, input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] readback;
		wait_drained();
		apb_access(1'b1, index, value, readback);
		if (index == int'(REG_COIN_SEED))
			sb.coin_seed = value[SEED_W-1:0];
		apb_access(1'b0, int'(REG_COIN_SEED), '0, readback);
		if (readback !== APB_DW'(sb.coin_seed))
			sb.flag("coin_seed readback", APB_DW'(sb.coin_seed), readback);
	endtask

	function automatic logic [KEY_W-1:0] held_key();
		if (sb.keys_held.size() == 0)
			return $urandom;
		return sb.keys_held[$urandom_range(0, sb.keys_held.size() - 1)];
	endfunction

	task automatic send_random(input int search_pct, input int add_pct);
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			func = FUNC_UNUSED;
		else if (r < 5 + search_pct)
			func = FUNC_SEARCH;
		else if (r < 5 + search_pct + add_pct)
			func = FUNC_ADD;
		else
			func = FUNC_ERASE;
		r = $urandom_range(0, 99);
		if (r < 40)
			key = held_key();
		else if (r < 75)
			key = KEY_W'($urandom_range(0, 63)) - 32;
		else
			key = $urandom;
		send_req(func, key);
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_on = 1'b1;
		hold_request = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(int'(REG_COIN_SEED), 32'h0000_0000);
		send_req(FUNC_SEARCH, 32'sd0);
		send_req(FUNC_ERASE, 32'sd5);
		send_req(FUNC_ADD, 32'sh8000_0000);
		send_req(FUNC_ADD, 32'sh7FFF_FFFF);
		send_req(FUNC_ADD, 32'sd0);
		send_req(FUNC_ADD, -32'sd1);
		send_req(FUNC_ADD, 32'sd1);
		send_req(FUNC_ADD, 32'sh7FFF_FFFF);
		send_req(FUNC_SEARCH, 32'sh8000_0000);
		send_req(FUNC_SEARCH, 32'sh7FFF_FFFF);
		send_req(FUNC_SEARCH, 32'sd2);
		send_req(FUNC_ERASE, 32'sd0);
		send_req(FUNC_SEARCH, 32'sd0);
		send_req(FUNC_ERASE, 32'sd0);
		send_req(FUNC_UNUSED, 32'sh5A5A_5A5A);
		send_req(FUNC_UNUSED, 32'sh8000_0000);
		send_req(FUNC_ADD, 32'sd0);
		send_req(FUNC_ERASE, 32'sh8000_0000);
		send_req(FUNC_ERASE, 32'sh7FFF_FFFF);
		send_req(FUNC_ADD, 32'shAAAA_AAAA);
		send_req(FUNC_ADD, 32'sh5555_5555);

		// A write to an unmapped register must leave the seed unchanged.
		write_reg(BAD_REG_INDEX, 32'h0000_1234);
		write_reg(int'(REG_COIN_SEED), 32'hFFFF_FFFF);
		for (int i = 0; i < 150; i++) begin
			idle_on = (i / 40) % 2 == 0;
			if (i == 70)
				hold_request = 1'b1;
			if (i == 120)
				wait_drained();
			send_random(30, 35);
		end

		write_reg(int'(REG_COIN_SEED), $urandom);
		n = 0;
		while (sb.keys_held.size() < NODES) begin
			idle_on = (n / 200) % 2 == 0;
			n = $urandom_range(0, 99) < 92 ? n + 1 : n + 1;
			case ($urandom_range(0, 19))
				0: send_req(FUNC_SEARCH, held_key());
				1: send_req(FUNC_ERASE, held_key());
				default: send_req(FUNC_ADD, $urandom);
			endcase
		end
		for (int i = 0; i < 40; i++) begin
			case ($urandom_range(0, 7))
				0: send_req(FUNC_ERASE, held_key());
				1: send_req(FUNC_SEARCH, held_key());
				2, 3: send_req(FUNC_ADD, held_key());
				default: send_req(FUNC_ADD, $urandom);
			endcase
		end

		write_reg(int'(REG_COIN_SEED), 32'h0000_0001);
		idle_on = 1'b0;
		for (int i = 0; i < 200; i++)
			send_random(15, 15);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Covered %0d requests: %0d hits, %0d inserts, %0d removals, %0d full refusals.",
			sb.requests, sb.hits, sb.inserts, sb.removals, sb.refusals);
		$display("Peak key count %0d under several coin seeds; %0d mismatches.",
			sb.peak_count, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== skiplist_sorted_set.f =====
rtl/skss_pkg.sv
rtl/skss_cell.sv
rtl/skss_or_tree.sv
rtl/skiplist_sorted_set.sv
dv/testbench.sv
